FILE: rtl/lrast_pkg.sv
// Shared constants, codes and controller/datapath interface types for the range add/sum tree.
package lrast_pkg;

  localparam int NUM_ELEMENTS = 1024;
  localparam int IDX_W        = 10;
  localparam int DATA_W       = 32;
  localparam int ADDR_W       = $clog2(NUM_ELEMENTS);
  // 1-based binary indexed tree keys run up to NUM_ELEMENTS + 1
  localparam int KEY_W        = $clog2(NUM_ELEMENTS + 2);
  // walk key may overshoot to 2 * NUM_ELEMENTS during an update walk
  localparam int WK_W         = KEY_W + 1;
  localparam int CMP_W        = ((KEY_W > IDX_W) ? KEY_W : IDX_W) + 1;

  typedef enum logic [1:0] {
    KIND_SET   = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // start key of a tree walk
  typedef enum logic [1:0] {
    KEY_HI   = 2'd0,  // R
    KEY_LOM1 = 2'd1,  // L - 1
    KEY_LO   = 2'd2,  // L
    KEY_HIP1 = 2'd3   // R + 1
  } key_sel_t;

  typedef enum logic [1:0] {
    MUL_NONE   = 2'd0,
    MUL_S1K0   = 2'd1,
    MUL_VAL_LO = 2'd2,
    MUL_VAL_HI = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic     clr;       // clear sweep write
    logic     load;      // input transaction accepted
    logic     wstart;    // start a tree walk
    logic     wupd;      // walk is an update (else prefix sum)
    key_sel_t key_sel;
    logic     neg;       // update walk adds negated deltas
    logic     wstep;     // consume read data of the current node
    mul_sel_t mul_sel;
    logic     save_pa;   // keep first prefix sum
    logic     set_diff;  // delta for a point set
    logic     out_cur;   // load range sum into output register
    logic     out_zero;  // load zero into output register
  } cmd_t;

  typedef struct packed {
    logic walk_end;
    logic clr_last;
    logic rng_empty;
    logic set_oob;
  } stat_t;

endpackage

FILE: rtl/lrast_ram.sv
// Generic simple dual-port RAM with registered read.
module lrast_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/lrast_dp.sv
// Datapath: twin binary indexed tree store, walk key, accumulators, multiplier, output register.
module lrast_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lrast_pkg::cmd_t              cmd,
  output lrast_pkg::stat_t             st,
  input  logic [1:0]                   in_kind,
  input  logic [lrast_pkg::IDX_W-1:0]  in_first_index,
  input  logic [lrast_pkg::IDX_W-1:0]  in_last_index,
  input  logic [lrast_pkg::DATA_W-1:0] in_operand,
  output logic [lrast_pkg::DATA_W-1:0] out_range_sum
);

  localparam int DW = lrast_pkg::DATA_W;
  localparam int AW = lrast_pkg::ADDR_W;
  localparam int KW = lrast_pkg::KEY_W;
  localparam int WW = lrast_pkg::WK_W;
  localparam int CW = lrast_pkg::CMP_W;

  logic [KW-1:0]   fk_r, rk_r, k0_r, key;
  logic [WW-1:0]   k_r, lowbit, k_next;
  logic [DW-1:0]   opnd_r, val_r, pa_r, prod_r, s1_r, s2_r, d1_r, d2_r, out_sum_r;
  logic [DW-1:0]   mul_a, mul_b, cur;
  logic            upd_r;
  logic [AW-1:0]   clr_r, node_addr;
  logic [CW-1:0]   first_x, last_x, top_x, last_c, rk_x;
  logic            we;
  logic [2*DW-1:0] wdata, rdata;

  // range decode of the incoming transaction
  always_comb begin
    first_x = CW'(in_first_index);
    last_x  = CW'(in_last_index);
    top_x   = CW'(lrast_pkg::NUM_ELEMENTS - 1);
    last_c  = (last_x > top_x) ? top_x : last_x;
    rk_x    = (in_kind == lrast_pkg::KIND_SET) ? first_x + CW'(1) : last_c + CW'(1);
  end

  assign st.rng_empty = first_x > last_c;
  assign st.set_oob   = first_x > top_x;
  assign st.clr_last  = clr_r == AW'(lrast_pkg::NUM_ELEMENTS - 1);

  // walk start key
  always_comb begin
    unique case (cmd.key_sel)
      lrast_pkg::KEY_HI:   key = rk_r;
      lrast_pkg::KEY_LOM1: key = fk_r;
      lrast_pkg::KEY_LO:   key = fk_r + KW'(1);
      lrast_pkg::KEY_HIP1: key = rk_r + KW'(1);
      default:             key = rk_r;
    endcase
  end

  // tree index stepping
  assign lowbit       = k_r & (~k_r + WW'(1));
  assign k_next       = upd_r ? k_r + lowbit : k_r & (k_r - WW'(1));
  assign st.walk_end  = upd_r ? (k_r > WW'(lrast_pkg::NUM_ELEMENTS)) : (k_r == '0);
  assign node_addr    = AW'(k_r - WW'(1));

  // multiplier operand select
  always_comb begin
    unique case (cmd.mul_sel)
      lrast_pkg::MUL_S1K0:   begin mul_a = s1_r;  mul_b = DW'(k0_r); end
      lrast_pkg::MUL_VAL_LO: begin mul_a = val_r; mul_b = DW'(fk_r); end
      lrast_pkg::MUL_VAL_HI: begin mul_a = val_r; mul_b = DW'(rk_r); end
      default:               begin mul_a = '0;    mul_b = '0;        end
    endcase
  end

  // element value or range sum from two prefix sums
  assign cur = pa_r - (prod_r - s2_r);

  // tree store: high half B1, low half B2
  assign we    = cmd.clr | (cmd.wstep & upd_r);
  assign wdata = cmd.clr ? '0 : {rdata[2*DW-1:DW] + d1_r, rdata[DW-1:0] + d2_r};

  lrast_ram #(
    .WIDTH (2 * DW),
    .DEPTH (lrast_pkg::NUM_ELEMENTS)
  ) u_tree (
    .clk   (clk),
    .we    (we),
    .waddr (cmd.clr ? clr_r : node_addr),
    .wdata (wdata),
    .raddr (node_addr),
    .rdata (rdata)
  );

  // clear sweep address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr) begin
      clr_r <= clr_r + AW'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fk_r   <= KW'(first_x);
      rk_r   <= KW'(rk_x);
      opnd_r <= in_operand;
      val_r  <= in_operand;
    end
    if (cmd.set_diff) begin
      val_r <= opnd_r - cur;
    end
    if (cmd.mul_sel != lrast_pkg::MUL_NONE) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.save_pa) begin
      pa_r <= prod_r - s2_r;
    end
    if (cmd.wstart) begin
      k_r   <= WW'(key);
      k0_r  <= key;
      upd_r <= cmd.wupd;
      s1_r  <= '0;
      s2_r  <= '0;
      d1_r  <= cmd.neg ? -val_r : val_r;
      d2_r  <= cmd.neg ? -prod_r : prod_r;
    end else if (cmd.wstep) begin
      k_r <= k_next;
      if (!upd_r) begin
        s1_r <= s1_r + rdata[2*DW-1:DW];
        s2_r <= s2_r + rdata[DW-1:0];
      end
    end
    if (cmd.out_cur) begin
      out_sum_r <= cur;
    end else if (cmd.out_zero) begin
      out_sum_r <= '0;
    end
  end

  assign out_range_sum = out_sum_r;

endmodule

FILE: rtl/lrast_ctrl.sv
// Controller: clear sweep, operation sequencing, tree walk loop and output handshake.
module lrast_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_kind,
  output logic             out_valid,
  input  logic             out_ready,
  output lrast_pkg::cmd_t  cmd,
  input  lrast_pkg::stat_t st
);

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_PA_START, ST_PA_MUL, ST_PA_SAVE, ST_PB_START, ST_PB_MUL,
    ST_PB_END, ST_UA_MUL, ST_UA_START, ST_UB_MUL, ST_UB_START, ST_WRD, ST_WRMW, ST_ZERO
  } state_t;

  state_t      state_r, state_nxt, ret_r, ret_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        accept, out_free;

  assign in_ready  = state_r == ST_IDLE;
  assign accept    = in_valid & in_ready;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    kind_nxt      = kind_r;
    out_valid_nxt = out_valid_r & !out_ready;
    cmd           = '0;
    cmd.key_sel   = lrast_pkg::KEY_HI;
    cmd.mul_sel   = lrast_pkg::MUL_NONE;
    unique case (state_r)
      ST_CLR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          kind_nxt = in_kind;
          unique case (in_kind)
            lrast_pkg::KIND_SET:   state_nxt = st.set_oob ? ST_IDLE : ST_PA_START;
            lrast_pkg::KIND_ADD:   state_nxt = st.rng_empty ? ST_IDLE : ST_UA_MUL;
            lrast_pkg::KIND_QUERY: state_nxt = st.rng_empty ? ST_ZERO : ST_PA_START;
            default:               state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PA_START: begin
        cmd.wstart  = 1'b1;
        cmd.key_sel = lrast_pkg::KEY_HI;
        ret_nxt     = ST_PA_MUL;
        state_nxt   = ST_WRD;
      end
      ST_PA_MUL: begin
        cmd.mul_sel = lrast_pkg::MUL_S1K0;
        state_nxt   = ST_PA_SAVE;
      end
      ST_PA_SAVE: begin
        cmd.save_pa = 1'b1;
        state_nxt   = ST_PB_START;
      end
      ST_PB_START: begin
        cmd.wstart  = 1'b1;
        cmd.key_sel = lrast_pkg::KEY_LOM1;
        ret_nxt     = ST_PB_MUL;
        state_nxt   = ST_WRD;
      end
      ST_PB_MUL: begin
        cmd.mul_sel = lrast_pkg::MUL_S1K0;
        state_nxt   = ST_PB_END;
      end
      ST_PB_END: begin
        if (kind_r == lrast_pkg::KIND_QUERY) begin
          if (out_free) begin
            cmd.out_cur   = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else begin
          cmd.set_diff = 1'b1;
          state_nxt    = ST_UA_MUL;
        end
      end
      ST_UA_MUL: begin
        cmd.mul_sel = lrast_pkg::MUL_VAL_LO;
        state_nxt   = ST_UA_START;
      end
      ST_UA_START: begin
        cmd.wstart  = 1'b1;
        cmd.wupd    = 1'b1;
        cmd.key_sel = lrast_pkg::KEY_LO;
        ret_nxt     = ST_UB_MUL;
        state_nxt   = ST_WRD;
      end
      ST_UB_MUL: begin
        cmd.mul_sel = lrast_pkg::MUL_VAL_HI;
        state_nxt   = ST_UB_START;
      end
      ST_UB_START: begin
        cmd.wstart  = 1'b1;
        cmd.wupd    = 1'b1;
        cmd.neg     = 1'b1;
        cmd.key_sel = lrast_pkg::KEY_HIP1;
        ret_nxt     = ST_IDLE;
        state_nxt   = ST_WRD;
      end
      // issue read of current node, or leave the walk
      ST_WRD: begin
        state_nxt = st.walk_end ? ret_r : ST_WRMW;
      end
      // accumulate or write back, step the key
      ST_WRMW: begin
        cmd.wstep = 1'b1;
        state_nxt = ST_WRD;
      end
      ST_ZERO: begin
        if (out_free) begin
          cmd.out_zero  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      ret_r       <= ST_IDLE;
      kind_r      <= lrast_pkg::KIND_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // no new input while the store is being cleared
  a_clr_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr |-> !in_ready) else $error("input accepted during clear sweep");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_cur || cmd.out_zero) |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

  // node data is consumed only right after its read was issued
  a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WRMW |-> $past(state_r) == ST_WRD) else $error("walk out of order");

  // a non-empty query cannot produce its result on the next edge
  a_query_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_kind == lrast_pkg::KIND_QUERY && !st.rng_empty) |=> !$rose(out_valid_r))
    else $error("query result too early");

endmodule

FILE: rtl/lazy_range_add_sum_tree_core.sv
// Top level: range add / range sum store with point set, controller plus datapath.
//
//  channel | signals                                       | direction
//  --------+-----------------------------------------------+----------
//  in      | in_valid in_ready in_kind in_first_index       | to core
//          | in_last_index in_operand                      |
//  out     | out_valid out_ready out_range_sum             | from core
//
// Store is a pair of binary indexed trees in one 64-bit RAM; each walk visits at
// most log2(NUM_ELEMENTS)+1 nodes, each as a registered RAM read, then an
// accumulate or read-modify-write step. Add: 2 update walks; query: 2 prefix
// walks; set: 2 prefix plus 2 update walks. Empty ops run no tree walk.
// After reset the RAM is cleared with in_ready low.
// A result waiting in the output register stalls only the next query's end.
module lazy_range_add_sum_tree_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_kind,
  input  logic [lrast_pkg::IDX_W-1:0]         in_first_index,
  input  logic [lrast_pkg::IDX_W-1:0]         in_last_index,
  input  logic signed [lrast_pkg::DATA_W-1:0] in_operand,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lrast_pkg::DATA_W-1:0] out_range_sum
);

  lrast_pkg::cmd_t  cmd;
  lrast_pkg::stat_t st;

  lrast_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_kind   (in_kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .st        (st)
  );

  lrast_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_kind        (in_kind),
    .in_first_index (in_first_index),
    .in_last_index  (in_last_index),
    .in_operand     (in_operand),
    .out_range_sum  (out_range_sum)
  );

endmodule

FILE: tb/sv/tb_lazy_range_add_sum_tree_core.sv
// Testbench for the range add / range sum store: directed and random operations checked against a flat array.
module tb_lazy_range_add_sum_tree_core;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int IDX_W = lrast_pkg::IDX_W;
  localparam int DATA_W = lrast_pkg::DATA_W;
  localparam int NUM_ELEMENTS = lrast_pkg::NUM_ELEMENTS;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_kind = lrast_pkg::KIND_NONE;
  logic [IDX_W-1:0] in_first_index = '0;
  logic [IDX_W-1:0] in_last_index = '0;
  logic signed [DATA_W-1:0] in_operand = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_range_sum;

  // element values as the store should hold them
  logic [DATA_W-1:0] element_val [NUM_ELEMENTS];
  logic [DATA_W-1:0] pending_sums [$];

  int mismatches = 0;
  int queries_sent = 0;
  int sums_checked = 0;
  int idle_cycles = 0;
  bit sink_idle_on = 1'b1;
  bit src_idle_on = 1'b1;
  bit hold_sink = 1'b0;

  lazy_range_add_sum_tree_core dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // apply one operation to the flat array; returns 1 and the sum for a query
  function automatic bit apply_op(input lrast_pkg::kind_t kind, input logic [IDX_W-1:0] lo,
                                  input logic [IDX_W-1:0] hi, input logic [DATA_W-1:0] opnd,
                                  output logic [DATA_W-1:0] sum);
    int last;
    last = (hi > NUM_ELEMENTS - 1) ? NUM_ELEMENTS - 1 : hi;
    sum = '0;
    case (kind)
      lrast_pkg::KIND_SET: begin
        if (lo < NUM_ELEMENTS) element_val[lo] = opnd;
        return 1'b0;
      end
      lrast_pkg::KIND_ADD: begin
        for (int i = lo; i <= last; i++) element_val[i] += opnd;
        return 1'b0;
      end
      lrast_pkg::KIND_QUERY: begin
        for (int i = lo; i <= last; i++) sum += element_val[i];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // send one transaction; prediction made at acceptance
  task automatic send_op(input lrast_pkg::kind_t kind, input logic [IDX_W-1:0] lo,
                         input logic [IDX_W-1:0] hi, input logic [DATA_W-1:0] opnd);
    logic [DATA_W-1:0] sum;
    int gap;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_first_index <= lo;
    in_last_index <= hi;
    in_operand <= opnd;
    do @(posedge clk); while (!in_ready);
    if (apply_op(kind, lo, hi, opnd, sum)) begin
      pending_sums.push_back(sum);
      queries_sent++;
    end
    // valid stays up; the next call replaces the payload or drops valid
    @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sum %0d", out_range_sum);
      end else begin
        logic [DATA_W-1:0] exp_sum;
        exp_sum = pending_sums.pop_front();
        sums_checked++;
        if (out_range_sum !== exp_sum) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sum mismatch: expected %0d got %0d", $signed(exp_sum), out_range_sum);
        end
      end
    end
  end

  // receiver: random stall bursts, or a long hold when asked
  initial begin
    int burst;
    forever begin
      @(negedge clk);
      if (hold_sink) out_ready <= 1'b0;
      else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 13);
        out_ready <= 1'b0;
        repeat (burst - 1) @(negedge clk);
      end else out_ready <= 1'b1;
    end
  end

  // watchdog on cycles without any input or output handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("tb_lazy_range_add_sum_tree_core: errors");
      $finish;
    end
  end

  function automatic logic [IDX_W-1:0] rand_idx();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return IDX_W'(NUM_ELEMENTS - 1);
      2: return IDX_W'($urandom_range(0, 15));
      default: return IDX_W'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_op(lrast_pkg::KIND_QUERY, 0, 1023, 0);
    send_op(lrast_pkg::KIND_SET, 0, 0, 32'h7fffffff);
    send_op(lrast_pkg::KIND_SET, 1023, 0, 32'h80000000);
    send_op(lrast_pkg::KIND_SET, 5, 3, 32'hffffffff);
    send_op(lrast_pkg::KIND_QUERY, 0, 1023, 0);
    send_op(lrast_pkg::KIND_ADD, 0, 1023, 32'h00000001);
    send_op(lrast_pkg::KIND_ADD, 3, 700, 32'h80000000);
    send_op(lrast_pkg::KIND_ADD, 9, 2, 32'h12345678);       // empty range
    send_op(lrast_pkg::KIND_SET, 5, 5, 32'h00000010);       // set after adds
    send_op(lrast_pkg::KIND_QUERY, 5, 5, 0);
    send_op(lrast_pkg::KIND_QUERY, 7, 6, 0);                // empty query
    send_op(lrast_pkg::KIND_QUERY, 1023, 1023, 0);
    send_op(lrast_pkg::KIND_QUERY, 0, 0, 0);
    send_op(lrast_pkg::KIND_NONE, 0, 1023, 32'hdeadbeef);   // unused kind
    send_op(lrast_pkg::KIND_QUERY, 2, 1023, 0);
    send_op(lrast_pkg::KIND_ADD, 1023, 1023, 32'h55555555);
    send_op(lrast_pkg::KIND_QUERY, 1000, 1023, 0);
  endtask

  task automatic test_random(input int count);
    lrast_pkg::kind_t kind;
    logic [IDX_W-1:0] lo, hi;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: kind = lrast_pkg::KIND_SET;
        3, 4, 5: kind = lrast_pkg::KIND_ADD;
        9:       kind = ($urandom_range(0, 3) == 0) ? lrast_pkg::KIND_NONE
                                                    : lrast_pkg::KIND_QUERY;
        default: kind = lrast_pkg::KIND_QUERY;
      endcase
      lo = rand_idx();
      hi = rand_idx();
      if (lo > hi && $urandom_range(0, 3) != 0) {lo, hi} = {hi, lo};
      send_op(kind, lo, hi, $urandom);
    end
  endtask

  // long receiver hold while queries keep coming
  task automatic test_backpressure();
    hold_sink = 1'b1;
    fork
      begin
        for (int n = 0; n < 6; n++) send_op(lrast_pkg::KIND_QUERY, 0, IDX_W'($urandom), 0);
      end
      begin
        repeat (600) @(negedge clk);
        hold_sink = 1'b0;
      end
    join
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    foreach (element_val[i]) element_val[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random(450);
    // final part without idling
    sink_idle_on = 1'b0;
    src_idle_on = 1'b0;
    test_random(180);
    drain();
    $display("ran directed, backpressure and random operations; %0d of %0d sums checked",
             sums_checked, queries_sent);
    if (mismatches == 0 && pending_sums.size() == 0)
      $display("tb_lazy_range_add_sum_tree_core: clean");
    else
      $display("tb_lazy_range_add_sum_tree_core: errors");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/lrast_pkg.sv
rtl/lrast_ram.sv
rtl/lrast_dp.sv
rtl/lrast_ctrl.sv
rtl/lazy_range_add_sum_tree_core.sv
tb/sv/tb_lazy_range_add_sum_tree_core.sv
